### sv/rsc_pkg.sv
package rsc_pkg;

	localparam int DATA_W      = 32;
	localparam int OP_W        = 4;
	localparam int DEPTH_NOW_W = 8;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;

	// command opcodes
	localparam logic [OP_W-1:0] OP_PUSH  = 4'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 4'd1;
	localparam logic [OP_W-1:0] OP_SUB   = 4'd2;
	localparam logic [OP_W-1:0] OP_MUL   = 4'd3;
	localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
	localparam logic [OP_W-1:0] OP_MOD   = 4'd5;
	localparam logic [OP_W-1:0] OP_PEEK  = 4'd6;
	localparam logic [OP_W-1:0] OP_DUP   = 4'd7;
	localparam logic [OP_W-1:0] OP_SWAP  = 4'd8;
	localparam logic [OP_W-1:0] OP_CLEAR = 4'd9;
	localparam logic [OP_W-1:0] OP_POP   = 4'd10;

	typedef struct packed {
		logic                   divide_by_zero;
		logic                   overflow;
		logic                   underflow;
		logic                   report_valid;
	} flags_t;

endpackage

### sv/rpn_stack_calculator.sv
// Channel   Dir  Width  Contents
// s_axis    in   40     command: opcode, operand
// m_axis    out  48+1   result: report value, flags, depth; tuser = report valid
//
// One command at a time. After a command is taken, s_axis_tready stays low until
// its result is loaded into the output register. Push, peek, dup, clear and pop
// act in the top-of-stack state; add/sub/mul, swap and div/mod also pop the second
// entry and push back, div/mod through the 32-step restoring divide loop on the
// shared 33-bit adder unless the divisor is zero. A new command may be taken
// while the previous result still waits on m_axis; a result that cannot be
// loaded holds the sequencer. Reset clears the stack count and the sequencer;
// stack storage is not cleared, and no entry is read before it is written.
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [3:0] opcode, [35:4] operand, [39:36] zero
	input  logic [rsc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] report_value, [32] underflow, [33] overflow, [34] divide_by_zero,
	// [42:35] depth_now, [47:43] zero
	output logic [rsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// [0] report_valid
	output logic                             m_axis_tuser
);

	localparam int DW = rsc_pkg::DATA_W;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int NW = rsc_pkg::DEPTH_NOW_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
	localparam logic [4:0]    LAST_ITR = 5'd31;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TOP, ST_SEC, ST_EXEC, ST_ABSA, ST_ABSB,
		ST_DIV, ST_DFIX, ST_PUSH, ST_PUSH2, ST_FIN
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                cnt_q;
	logic [rsc_pkg::OP_W-1:0]     op_q;
	logic [DW-1:0]                opd_q;
	logic [DW-1:0]                x1_q;   // first pop (right operand)
	logic [DW-1:0]                x2_q;   // second pop (left operand)
	logic [DW-1:0]                res_q;
	logic [DW-1:0]                rep_q;
	logic [DW-1:0]                quo_q;
	logic [DW-1:0]                rem_q;
	logic [DW-1:0]                dvs_q;
	logic [4:0]                   itr_q;
	logic                         und_q, ovf_q, dz_q;
	logic                         m_valid_q;
	logic [rsc_pkg::OUT_TDATA_W-1:0] m_data_q;
	logic                         m_user_q;

	logic                         empty, full, accept, mod_op;
	logic                         load_out;
	logic [DW:0]                  alu_a, alu_b, alu_sum;
	logic                         alu_sub;
	logic [DW-1:0]                div_shift;
	logic [DW-1:0]                prod;
	logic                         ram_we;
	logic [DW-1:0]                ram_wdata, ram_rdata;
	logic [AW-1:0]                ram_raddr;
	logic [CW-1:0]                raddr_full;
	logic [CW+NW-1:0]             cnt_ext;
	rsc_pkg::flags_t              flags;

	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q == FULL_CNT);
	assign mod_op = (op_q == rsc_pkg::OP_MOD);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	// result goes out when the output register is free or drains this cycle
	assign load_out = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);

	// Top of stack is read at the accept; the entry below it in the next cycle,
	// at count minus two, before the first pop has lowered the count.
	assign raddr_full = (state_q == ST_TOP) ? cnt_q - CW'(2) : cnt_q - CW'(1);
	assign ram_raddr  = raddr_full[AW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = res_q;
		unique case (state_q)
			ST_TOP: begin
				if (op_q == rsc_pkg::OP_PUSH && !full) begin
					ram_we    = 1'b1;
					ram_wdata = opd_q;
				end else if (op_q == rsc_pkg::OP_DUP && !empty && !full) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
				end
			end
			ST_PUSH: begin
				ram_we    = !full;
				ram_wdata = res_q;
			end
			ST_PUSH2: begin
				ram_we    = !full;
				ram_wdata = x2_q;
			end
			default: ;
		endcase
	end

	rsc_ram #(
		.WIDTH(DW),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Shared adder: add/sub, negation for magnitudes and sign fix, divide steps.
	assign div_shift = {rem_q[DW-2:0], quo_q[DW-1]};

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				alu_a   = {1'b0, x2_q};
				alu_b   = {1'b0, x1_q};
				alu_sub = (op_q == rsc_pkg::OP_SUB);
			end
			ST_ABSA: begin
				alu_b   = {1'b0, x2_q};
				alu_sub = 1'b1;
			end
			ST_ABSB: begin
				alu_b   = {1'b0, x1_q};
				alu_sub = 1'b1;
			end
			ST_DIV: begin
				alu_a   = {1'b0, div_shift};
				alu_b   = {1'b0, dvs_q};
				alu_sub = 1'b1;
			end
			ST_DFIX: begin
				alu_b   = {1'b0, (mod_op ? rem_q : quo_q)};
				alu_sub = 1'b1;
			end
			default: ;
		endcase
		alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{DW{1'b0}}, alu_sub};
	end

	assign prod = x2_q * x1_q;   // low word only, wraps

	assign cnt_ext              = {{NW{1'b0}}, cnt_q};
	assign flags.report_valid   = (op_q == rsc_pkg::OP_PEEK) || (op_q == rsc_pkg::OP_POP);
	assign flags.underflow      = und_q;
	assign flags.overflow       = ovf_q;
	assign flags.divide_by_zero = dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= s_axis_tdata[3:0];
						opd_q   <= s_axis_tdata[35:4];
						und_q   <= 1'b0;
						ovf_q   <= 1'b0;
						dz_q    <= 1'b0;
						rep_q   <= '0;
						state_q <= ST_TOP;
					end
				end
				ST_TOP: begin
					state_q <= ST_FIN;
					unique case (op_q) inside
						rsc_pkg::OP_PUSH: begin
							if (full) ovf_q <= 1'b1;
							else cnt_q <= cnt_q + CW'(1);
						end
						rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MUL,
						rsc_pkg::OP_DIV, rsc_pkg::OP_MOD, rsc_pkg::OP_SWAP: begin
							if (empty) begin
								x1_q  <= '1;
								und_q <= 1'b1;
							end else begin
								x1_q  <= ram_rdata;
								cnt_q <= cnt_q - CW'(1);
							end
							state_q <= ST_SEC;
						end
						rsc_pkg::OP_PEEK: begin
							if (empty) begin
								rep_q <= '1;
								und_q <= 1'b1;
							end else begin
								rep_q <= ram_rdata;
							end
						end
						rsc_pkg::OP_DUP: begin
							if (empty) und_q <= 1'b1;
							else if (full) ovf_q <= 1'b1;
							else cnt_q <= cnt_q + CW'(1);
						end
						rsc_pkg::OP_CLEAR: begin
							cnt_q <= '0;
						end
						rsc_pkg::OP_POP: begin
							if (empty) begin
								rep_q <= '1;
								und_q <= 1'b1;
							end else begin
								rep_q <= ram_rdata;
								cnt_q <= cnt_q - CW'(1);
							end
						end
						default: ;   // unused opcodes: no operation
					endcase
				end
				ST_SEC: begin
					if (empty) begin
						x2_q  <= '1;
						und_q <= 1'b1;
					end else begin
						x2_q  <= ram_rdata;
						cnt_q <= cnt_q - CW'(1);
					end
					unique case (op_q) inside
						rsc_pkg::OP_DIV, rsc_pkg::OP_MOD: begin
							if (x1_q == '0) begin
								dz_q    <= 1'b1;
								res_q   <= '0;
								state_q <= ST_PUSH;
							end else begin
								state_q <= ST_ABSA;
							end
						end
						rsc_pkg::OP_SWAP: begin
							res_q   <= x1_q;
							state_q <= ST_PUSH;
						end
						default: state_q <= ST_EXEC;
					endcase
				end
				ST_EXEC: begin
					res_q   <= (op_q == rsc_pkg::OP_MUL) ? prod : alu_sum[DW-1:0];
					state_q <= ST_PUSH;
				end
				ST_ABSA: begin
					quo_q   <= x2_q[DW-1] ? alu_sum[DW-1:0] : x2_q;
					rem_q   <= '0;
					state_q <= ST_ABSB;
				end
				ST_ABSB: begin
					dvs_q   <= x1_q[DW-1] ? alu_sum[DW-1:0] : x1_q;
					itr_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// restoring step: keep the difference when it is not negative
					if (!alu_sum[DW]) begin
						rem_q <= alu_sum[DW-1:0];
						quo_q <= {quo_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= div_shift;
						quo_q <= {quo_q[DW-2:0], 1'b0};
					end
					itr_q <= itr_q + 5'd1;
					if (itr_q == LAST_ITR) state_q <= ST_DFIX;
				end
				ST_DFIX: begin
					// remainder takes the dividend's sign, quotient the sign product
					if (mod_op ? x2_q[DW-1] : (x2_q[DW-1] ^ x1_q[DW-1])) begin
						res_q <= alu_sum[DW-1:0];
					end else begin
						res_q <= mod_op ? rem_q : quo_q;
					end
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (full) ovf_q <= 1'b1;
					else cnt_q <= cnt_q + CW'(1);
					state_q <= (op_q == rsc_pkg::OP_SWAP) ? ST_PUSH2 : ST_FIN;
				end
				ST_PUSH2: begin
					if (full) ovf_q <= 1'b1;
					else cnt_q <= cnt_q + CW'(1);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (load_out) begin
						m_data_q  <= {5'd0, cnt_ext[NW-1:0], flags.divide_by_zero,
						              flags.overflow, flags.underflow, rep_q};
						m_user_q  <= flags.report_valid;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

### sv/rsc_ram.sv
module rsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### dv/calc_checker.sv
`timescale 1ns / 100ps

// Watches both streams, runs a stack model on every accepted command and
// compares each result request against the oldest prediction.
module calc_checker
	import rsc_pkg::*;
#(
	parameter int STACK_DEPTH = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   m_axis_tuser,
	output int                     errors,
	output int                     outstanding
);

	typedef struct packed {
		logic [DATA_W-1:0]      value;
		logic                   report_valid;
		logic                   underflow;
		logic                   overflow;
		logic                   divide_by_zero;
		logic [DEPTH_NOW_W-1:0] depth_now;
	} calc_result_t;

	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
	int unsigned       stack_ptr = 0;
	bit                saw_under;
	bit                saw_over;
	calc_result_t      result_q [$];
	int                results_seen = 0;
	int                error_count = 0;
	int                pending_q = 0;

	assign errors      = error_count;
	assign outstanding = pending_q;

	function automatic void model_push(logic [DATA_W-1:0] v);
		if (stack_ptr >= STACK_DEPTH) begin
			saw_over = 1'b1;
		end else begin
			stack_mem[stack_ptr] = v;
			stack_ptr++;
		end
	endfunction

	// empty stack reads back as all ones
	function automatic logic [DATA_W-1:0] model_pop();
		if (stack_ptr == 0) begin
			saw_under = 1'b1;
			return '1;
		end
		stack_ptr--;
		return stack_mem[stack_ptr];
	endfunction

	// 64-bit math keeps most-negative / -1 well defined; truncates toward zero
	function automatic logic [DATA_W-1:0] signed_divide(logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b, bit want_rem);
		longint sa;
		longint sb;
		longint q;
		sa = longint'($signed(a));
		sb = longint'($signed(b));
		q  = want_rem ? (sa % sb) : (sa / sb);
		return q[DATA_W-1:0];
	endfunction

	function automatic calc_result_t apply_command(logic [OP_W-1:0] op,
			logic [DATA_W-1:0] val);
		calc_result_t r;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		r = '0;
		saw_under = 1'b0;
		saw_over  = 1'b0;
		case (op) inside
			OP_PUSH: model_push(val);
			OP_ADD, OP_SUB, OP_MUL: begin
				b = model_pop();
				a = model_pop();
				if (op == OP_ADD)      model_push(a + b);
				else if (op == OP_SUB) model_push(a - b);
				else                   model_push(a * b);
			end
			OP_DIV, OP_MOD: begin
				b = model_pop();
				a = model_pop();
				if (b == '0) begin
					r.divide_by_zero = 1'b1;
					model_push('0);
				end else begin
					model_push(signed_divide(a, b, op == OP_MOD));
				end
			end
			OP_PEEK: begin
				r.report_valid = 1'b1;
				if (stack_ptr == 0) begin
					saw_under = 1'b1;
					r.value   = '1;
				end else begin
					r.value = stack_mem[stack_ptr-1];
				end
			end
			OP_DUP: begin
				if (stack_ptr == 0) saw_under = 1'b1;
				else                model_push(stack_mem[stack_ptr-1]);
			end
			OP_SWAP: begin
				a = model_pop();
				b = model_pop();
				model_push(a);
				model_push(b);
			end
			OP_CLEAR: stack_ptr = 0;
			OP_POP: begin
				r.report_valid = 1'b1;
				r.value        = model_pop();
			end
			default: ;
		endcase
		r.underflow = saw_under;
		r.overflow  = saw_over;
		r.depth_now = stack_ptr[DEPTH_NOW_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
			logic [DATA_W-1:0] want);
		$display("%0t ns: result %0d %s mismatch: got %0h, expected %0h",
			$time, results_seen, field, got, want);
		error_count++;
	endtask

	task automatic check_result(calc_result_t want);
		if (m_axis_tdata[31:0] !== want.value)
			report_mismatch("report_value", m_axis_tdata[31:0], want.value);
		if (m_axis_tuser !== want.report_valid)
			report_mismatch("report_valid", DATA_W'(m_axis_tuser),
				DATA_W'(want.report_valid));
		if (m_axis_tdata[32] !== want.underflow)
			report_mismatch("underflow", DATA_W'(m_axis_tdata[32]),
				DATA_W'(want.underflow));
		if (m_axis_tdata[33] !== want.overflow)
			report_mismatch("overflow", DATA_W'(m_axis_tdata[33]),
				DATA_W'(want.overflow));
		if (m_axis_tdata[34] !== want.divide_by_zero)
			report_mismatch("divide_by_zero", DATA_W'(m_axis_tdata[34]),
				DATA_W'(want.divide_by_zero));
		if (m_axis_tdata[42:35] !== want.depth_now)
			report_mismatch("depth_now", DATA_W'(m_axis_tdata[42:35]),
				DATA_W'(want.depth_now));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			stack_ptr = 0;
			result_q.delete();
			pending_q <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				result_q.push_back(apply_command(s_axis_tdata[OP_W-1:0],
					s_axis_tdata[OP_W+DATA_W-1:OP_W]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_q.size() == 0)
					report_mismatch("unexpected request", m_axis_tdata[31:0], '0);
				else
					check_result(result_q.pop_front());
				results_seen++;
			end
			pending_q <= result_q.size();
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import rsc_pkg::*;

	localparam int              DEPTH         = 128;
	localparam int              RANDOM_CMDS   = 1250;
	localparam logic [OP_W-1:0] OP_LAST_CODE  = 4'hF;
	localparam logic [DATA_W-1:0] MOST_NEG    = 32'h8000_0000;
	localparam logic [DATA_W-1:0] MOST_POS    = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] MINUS_ONE   = 32'hFFFF_FFFF;

	// command mix of one random phase
	typedef enum {MODE_BUILD, MODE_MIX, MODE_DRAIN, MODE_NOISE} mode_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	int                     errors;
	int                     outstanding;
	bit                     calm = 1'b0;
	int                     cmds_sent = 0;

	rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	calc_checker #(.STACK_DEPTH(DEPTH)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side back-pressure, off during the calm stretch
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 16);
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
		while (!calm && $urandom_range(0, 99) < 16) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W-OP_W-DATA_W){1'b0}}, val, op};
		do @(posedge clk); while (!s_axis_tready);
		cmds_sent++;
	endtask

	// hold off until every result request has drained
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [DATA_W-1:0] rand_operand();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 32'd1;
			2:       return MINUS_ONE;
			3:       return MOST_NEG;
			4:       return MOST_POS;
			5, 6:    return DATA_W'(int'($urandom_range(0, 40)) - 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op(mode_t mode);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		case (mode)
			MODE_BUILD: begin
				if (roll < 65)      return OP_PUSH;
				else if (roll < 75) return OP_DUP;
				else if (roll < 80) return OP_PEEK;
				else if (roll < 85) return OP_SWAP;
				else                return OP_W'($urandom_range(OP_ADD, OP_MOD));
			end
			MODE_DRAIN: begin
				if (roll < 15)      return OP_PUSH;
				else if (roll < 45) return OP_POP;
				else if (roll < 75) return OP_W'($urandom_range(OP_ADD, OP_MOD));
				else if (roll < 85) return OP_PEEK;
				else if (roll < 92) return OP_SWAP;
				else if (roll < 97) return OP_DUP;
				else                return OP_CLEAR;
			end
			MODE_MIX: begin
				if (roll < 40)      return OP_PUSH;
				else if (roll < 65) return OP_W'($urandom_range(OP_ADD, OP_MOD));
				else if (roll < 75) return OP_POP;
				else if (roll < 82) return OP_PEEK;
				else if (roll < 88) return OP_DUP;
				else if (roll < 95) return OP_SWAP;
				else if (roll < 98) return OP_CLEAR;
				else                return OP_W'($urandom_range(OP_POP + 1, OP_LAST_CODE));
			end
			default: return OP_W'($urandom_range(OP_PUSH, OP_LAST_CODE));
		endcase
	endfunction

	initial begin
		mode_t mode;
		int    phase;
		int    phase_len;
		int    guard;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-stack reads
		send_cmd(OP_POP, MOST_POS);
		send_cmd(OP_PEEK, '0);
		send_cmd(OP_DUP, '0);
		send_cmd(OP_SWAP, '0);              // -1, -1
		send_cmd(OP_CLEAR, MINUS_ONE);
		send_cmd(OP_PUSH, 32'd42);
		send_cmd(OP_SWAP, '0);              // 42 below -1
		send_cmd(OP_CLEAR, '0);
		// most negative over minus one, wrap on add
		send_cmd(OP_PUSH, MOST_NEG);
		send_cmd(OP_PUSH, MINUS_ONE);
		send_cmd(OP_DIV, '0);
		send_cmd(OP_PUSH, MINUS_ONE);
		send_cmd(OP_MOD, '0);
		send_cmd(OP_PUSH, MOST_POS);
		send_cmd(OP_PUSH, 32'd1);
		send_cmd(OP_ADD, '0);
		// zero divisor on both div and mod
		send_cmd(OP_PUSH, '0);
		send_cmd(OP_DIV, '0);
		send_cmd(OP_MOD, '0);
		// truncated remainder of a negative dividend
		send_cmd(OP_PUSH, -32'sd7);
		send_cmd(OP_PUSH, 32'd2);
		send_cmd(OP_MOD, '0);
		send_cmd(OP_DUP, '0);
		send_cmd(OP_MUL, '0);
		send_cmd(OP_SUB, '0);
		send_cmd(OP_PEEK, '0);
		send_cmd(OP_LAST_CODE, MINUS_ONE);
		send_cmd(OP_POP, '0);
		send_cmd(OP_ADD, '0);               // both operands missing
		send_cmd(OP_CLEAR, '0);
		drain_results();

		// random phases; the first one fills the stack past full
		cmds_sent = 0;
		phase     = 0;
		while (cmds_sent < RANDOM_CMDS) begin
			if (phase == 0) begin
				mode      = MODE_BUILD;
				phase_len = 300;
			end else begin
				mode      = mode_t'($urandom_range(0, 3));
				phase_len = $urandom_range(40, 160);
			end
			if (phase_len > RANDOM_CMDS - cmds_sent)
				phase_len = RANDOM_CMDS - cmds_sent;
			calm = (phase == 2);
			repeat (phase_len) send_cmd(pick_op(mode), rand_operand());
			if ($urandom_range(0, 2) == 0) drain_results();
			phase++;
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (outstanding != 0 && guard < 5000);
		repeat (60) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
sv/rsc_pkg.sv
sv/rsc_ram.sv
sv/rpn_stack_calculator.sv
dv/calc_checker.sv
dv/testbench.sv
